@@ rtl/ucf_pkg.sv @@
// Package for the UTF-8 case folding stream unit.
// Payload, burst and status types; lead and fold helpers; no dependencies.
package ucf_pkg;

   localparam int UCF_QUEUE_DEPTH = 4;
   localparam int UCF_BURST_MAX   = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       text_done;
   } rsp_type;

   // All output bytes caused by one input item.
   typedef struct packed {
      logic [UCF_BURST_MAX-1:0][7:0] bytes;
      logic [2:0]                    count;
      logic                          eot;
   } burst_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Sequence length announced by a lead byte, 0 when it is no valid lead.
   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if (b >= 8'hC2 && b <= 8'hDF) len = 3'd2;
      else if (b >= 8'hE0 && b <= 8'hEF) len = 3'd3;
      else if (b >= 8'hF0 && b <= 8'hF4) len = 3'd4;
      return len;
   endfunction

   function automatic logic [7:0] fold_ascii(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= 8'h41 && b <= 8'h5A) r = b + 8'h20;
      return r;
   endfunction

   // Fold a two-byte code point (U+0080..U+07FF).
   function automatic logic [10:0] fold_cp2(input logic [10:0] cp);
      logic [10:0] r;
      r = cp;
      if (cp >= 11'h410 && cp <= 11'h42F) r = cp + 11'h020;
      else if (cp >= 11'h400 && cp <= 11'h40F) r = cp + 11'h050;
      return r;
   endfunction

endpackage

@@ rtl/ucf_front.sv @@
// Front end: accepts bytes, tracks the held sequence and builds one burst per item.
// Depends on ucf_pkg.
module ucf_front
   import ucf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req_data,
   output logic      burst_valid,
   output burst_type burst
);

   logic [2:0][7:0] pend_ff, pend_in;
   logic [1:0]      pc_ff, pc_in;
   logic [2:0]      exp_ff, exp_in;

   logic [7:0]  b;
   logic        eot;
   logic        is_cont;
   logic        is_ascii;
   logic [2:0]  lead;
   logic        lead_hold;
   logic        have_pend;
   logic        complete;
   logic        emit_pend;
   logic        emit_cur;
   logic [7:0]  cur_out;
   logic [7:0]  first_out;
   logic [10:0] folded;
   logic        fold2;

   always_comb begin
      b         = req_data.in_byte;
      eot       = req_data.end_of_text;
      is_cont   = (b[7:6] == 2'b10);
      is_ascii  = ~b[7];
      lead      = lead_len(b);
      lead_hold = (lead != 3'd0) && !eot;
      have_pend = (pc_ff != 2'd0);
      complete  = have_pend && is_cont && (({1'b0, pc_ff} + 3'd1) >= exp_ff);

      // Of multibyte sequences only two-byte ones fold; longer ones pass unchanged.
      folded = fold_cp2({pend_ff[0][4:0], b[5:0]});
      fold2  = complete && (exp_ff == 3'd2);

      cur_out   = is_ascii ? fold_ascii(b) : b;
      first_out = pend_ff[0];
      if (fold2) begin
         first_out = {3'b110, folded[10:6]};
         cur_out   = {2'b10, folded[5:0]};
      end

      emit_pend = have_pend && (complete || eot || !is_cont);
      if (!have_pend || !is_cont) emit_cur = !lead_hold;
      else emit_cur = complete || eot;

      burst.eot = eot;
      burst.bytes = '0;
      if (emit_pend) begin
         burst.bytes[0] = first_out;
         burst.bytes[1] = pend_ff[1];
         burst.bytes[2] = pend_ff[2];
         for (int i = 0; i < UCF_BURST_MAX; i++) begin
            if (i[1:0] == pc_ff && emit_cur) burst.bytes[i] = cur_out;
         end
         burst.count = {1'b0, pc_ff} + {2'b00, emit_cur};
      end else begin
         burst.bytes[0] = cur_out;
         burst.count    = {2'b00, emit_cur};
      end
      burst_valid = accept && (burst.count != 3'd0);

      // Next sequence state.
      pend_in = pend_ff;
      pc_in   = pc_ff;
      exp_in  = exp_ff;
      if (!have_pend || !is_cont) begin
         if (lead_hold) begin
            pend_in[0] = b;
            pc_in      = 2'd1;
            exp_in     = lead;
         end else begin
            pc_in  = 2'd0;
            exp_in = 3'd0;
         end
      end else if (complete || eot) begin
         pc_in  = 2'd0;
         exp_in = 3'd0;
      end else begin
         pend_in[pc_ff] = b;
         pc_in          = pc_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= 2'd0;
         exp_ff <= 3'd0;
      end else if (accept) begin
         pc_ff  <= pc_in;
         exp_ff <= exp_in;
      end
   end

endmodule

@@ rtl/ucf_queue.sv @@
// Short burst queue between front and back end.
// Depends on ucf_pkg.
module ucf_queue
   import ucf_pkg::*;
#(
   parameter int DEPTH = UCF_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  burst_type        wr_data,
   input  logic             rd_en,
   output burst_type        rd_data,
   output queue_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   burst_type       mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_wr, do_rd;

   always_comb begin
      status.full  = (count_ff == CW'(DEPTH));
      status.empty = (count_ff == '0);
      do_wr = wr_en && !status.full;
      do_rd = rd_en && !status.empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_wr) wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      if (do_rd) rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      count_in = count_ff + CW'(do_wr) - CW'(do_rd);
      rd_data  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/ucf_back.sv @@
// Back end: walks each burst one byte a beat into the output register.
// Depends on ucf_pkg.
module ucf_back
   import ucf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  burst_type        head,
   input  queue_status_type q_status,
   output logic             deq,
   input  logic             pop,
   output logic             empty,
   output rsp_type          rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;
   logic       load;
   logic       last;

   always_comb begin
      load = !q_status.empty && (!out_valid_ff || pop);
      last = ({1'b0, idx_ff} == (head.count - 3'd1));
      deq  = load && last;

      idx_in       = idx_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop;
      if (load) begin
         out_in.out_byte  = head.bytes[idx_ff];
         out_in.run_last  = last;
         out_in.text_done = last && head.eot;
         out_valid_in     = 1'b1;
         idx_in           = last ? 2'd0 : idx_ff + 2'd1;
      end

      empty    = !out_valid_ff;
      rsp_data = out_ff;
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

@@ rtl/utf8_case_fold_stream_unit.sv @@
// UTF-8 validating case folder, top level.
// Channels: byte input (push/full) and byte output (pop/empty) look like queues.
// Each accepted byte yields zero to four output bytes; the last byte of each
// item's run has run_last set, and the last byte of a text has text_done set.
// Valid sequences are case-folded (A-Z, U+0400..U+042F); anything invalid,
// truncated or broken by a non-continuation byte passes through unchanged.
// Path: the edge that accepts an item writes its burst into the queue; its
// bytes then move from the queue into the output register whenever that
// register is empty or being popped.
// Throughput: one input byte a cycle while full is low; output runs at one byte a
// cycle while the receiver pops, one byte of an item's run at a time. The burst queue
// (QUEUE_DEPTH entries) absorbs these runs; full rises only when it is filled.
// Held lead and continuation bytes produce no output.
// Reset (synchronous, active high) empties the queue, drops the held
// sequence and marks the output register empty. When the receiver stalls, the
// output byte holds, the queue fills and full then stops the input side.
module utf8_case_fold_stream_unit
   import ucf_pkg::*;
#(
   parameter int QUEUE_DEPTH = UCF_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic             accept;
   logic             burst_valid;
   burst_type        burst;
   burst_type        head;
   logic             deq;
   queue_status_type q_status;

   assign full   = q_status.full;
   assign accept = push && !q_status.full;

   ucf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .burst_valid (burst_valid),
      .burst       (burst)
   );

   ucf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (burst_valid),
      .wr_data (burst),
      .rd_en   (deq),
      .rd_data (head),
      .status  (q_status)
   );

   ucf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .deq      (deq),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule

@@ rtl/ucf_checker.sv @@
// Port-level checks for the UTF-8 case folding stream unit, bound to its top level.
// Depends on ucf_pkg and utf8_case_fold_stream_unit.
module ucf_checker
   import ucf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    push,
   input logic    full,
   input req_type req_data,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   a_reset_clear : assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("outputs not cleared after reset");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_done_last : assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.text_done |-> rsp_data.run_last)
      else $error("text_done without run_last");

   a_eot_out : assert property (@(posedge clock) disable iff (reset)
      push && !full && req_data.end_of_text |-> ##2 !empty)
      else $error("end of text produced no result");

endmodule

bind utf8_case_fold_stream_unit ucf_checker u_chk (
   .clock    (clock),
   .reset    (reset),
   .push     (push),
   .full     (full),
   .req_data (req_data),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
